/* design/traffic_light_lane_queue_controller_macros.svh */
// Assertion helpers for the traffic light lane queue controller.
// Each macro expects clk and arst_n in the enclosing module.
`ifndef TRAFFIC_LIGHT_LANE_QUEUE_CONTROLLER_MACROS_SVH
`define TRAFFIC_LIGHT_LANE_QUEUE_CONTROLLER_MACROS_SVH

// Check a property on every rising edge outside reset.
`define TLQC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition implies another in the same cycle.
`define TLQC_ASSERT_IMPL(lbl, ante, cons, msg) \
	`TLQC_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

/* design/tlqc_pkg.sv */
package tlqc_pkg;

	localparam int CAR_ID_W  = 16;
	localparam int TICK_W    = 16;
	localparam int CFG_IDX_W = 8;
	localparam int COUNT_W   = 5;

	localparam logic [TICK_W-1:0] GREEN_RESET  = 16'd5;
	localparam logic [TICK_W-1:0] YELLOW_RESET = 16'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_GREEN  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_YELLOW = 8'd1;

	typedef enum logic [1:0] {
		KIND_TICK,
		KIND_ARRIVE,
		KIND_REQUEST,
		KIND_DONE
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_FULL,
		ST_WAIT,
		ST_EMPTY
	} status_t;

	typedef enum logic [1:0] {
		LIGHT_RED,
		LIGHT_YELLOW,
		LIGHT_GREEN
	} light_t;

	typedef enum logic [1:0] {
		PH_B_GREEN,
		PH_B_YELLOW,
		PH_A_GREEN,
		PH_A_YELLOW
	} phase_t;

	typedef struct packed {
		kind_t                kind;
		logic [1:0]           approach;
		logic [CAR_ID_W-1:0]  car_id;
	} in_word_t;

	typedef struct packed {
		status_t              status;
		light_t               light;
		logic [COUNT_W-1:0]   queue_count;
	} out_word_t;

	typedef struct packed {
		logic       push;
		logic       pop;
		logic [1:0] approach;
	} lane_ctl_t;

	// Approaches 2 and 3 belong to group B, 0 and 1 to group A.
	function automatic light_t light_of(input logic [1:0] appr, input phase_t ph);
		light_t l;
		l = LIGHT_RED;
		if (appr[1]) begin
			if (ph == PH_B_GREEN) l = LIGHT_GREEN;
			else if (ph == PH_B_YELLOW) l = LIGHT_YELLOW;
		end else begin
			if (ph == PH_A_GREEN) l = LIGHT_GREEN;
			else if (ph == PH_A_YELLOW) l = LIGHT_YELLOW;
		end
		return l;
	endfunction

endpackage

/* design/tlqc_phase.sv */
module tlqc_phase (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              tick,
	input  logic                              cfg_we,
	input  logic [tlqc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tlqc_pkg::TICK_W-1:0]       cfg_data,
	output tlqc_pkg::phase_t                  phase_d
);
	import tlqc_pkg::*;

	phase_t              phase_q;
	logic [TICK_W-1:0]   ticks_q;
	logic [TICK_W-1:0]   green_q;
	logic [TICK_W-1:0]   yellow_q;
	logic [TICK_W-1:0]   len;
	logic [TICK_W-1:0]   len_eff;
	logic [TICK_W-1:0]   ticks_inc;
	logic                wrap;

	always_comb begin
		len       = phase_q[0] ? yellow_q : green_q;
		len_eff   = (len == '0) ? TICK_W'(1) : len;
		ticks_inc = ticks_q + TICK_W'(1);
		wrap      = (ticks_inc >= len_eff);
		phase_d   = (tick && wrap) ? phase_t'(2'(phase_q + 2'd1)) : phase_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_B_GREEN;
			ticks_q  <= '0;
			green_q  <= GREEN_RESET;
			yellow_q <= YELLOW_RESET;
		end else begin
			if (tick) begin
				phase_q <= phase_d;
				ticks_q <= wrap ? '0 : ticks_inc;
			end
			// drop writes to unknown indexes
			if (cfg_we) begin
				case (cfg_index)
					CFG_GREEN:  green_q  <= cfg_data;
					CFG_YELLOW: yellow_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

/* design/tlqc_lanes.sv */
module tlqc_lanes #(
	parameter int QUEUE_DEPTH = 16,
	parameter int STORE_W     = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tlqc_pkg::lane_ctl_t                ctl,
	input  logic [STORE_W-1:0]                 wr_id,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]   count_cur,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]   count_nxt,
	output logic [STORE_W-1:0]                 head_s1
);
	import tlqc_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W = PTR_W + 2;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	logic [STORE_W-1:0] mem [1 << ADDR_W];
	logic [PTR_W-1:0]   wr_ptr_q [4];
	logic [PTR_W-1:0]   rd_ptr_q [4];
	logic [CNT_W-1:0]   cnt_q [4];
	logic [ADDR_W-1:0]  wr_addr;
	logic [ADDR_W-1:0]  rd_addr;

	always_comb begin
		count_cur = cnt_q[ctl.approach];
		count_nxt = count_cur;
		if (ctl.push) count_nxt = count_cur + CNT_W'(1);
		else if (ctl.pop) count_nxt = count_cur - CNT_W'(1);
		wr_addr = {ctl.approach, wr_ptr_q[ctl.approach]};
		rd_addr = {ctl.approach, rd_ptr_q[ctl.approach]};
	end

	always_ff @(posedge clk) begin
		if (ctl.push) mem[wr_addr] <= wr_id;
		head_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				wr_ptr_q[i] <= '0;
				rd_ptr_q[i] <= '0;
				cnt_q[i]    <= '0;
			end
		end else begin
			cnt_q[ctl.approach] <= count_nxt;
			if (ctl.push) begin
				wr_ptr_q[ctl.approach] <= (wr_ptr_q[ctl.approach] == PTR_LAST) ? '0 :
					wr_ptr_q[ctl.approach] + PTR_W'(1);
			end
			if (ctl.pop) begin
				rd_ptr_q[ctl.approach] <= (rd_ptr_q[ctl.approach] == PTR_LAST) ? '0 :
					rd_ptr_q[ctl.approach] + PTR_W'(1);
			end
		end
	end

endmodule

/* design/traffic_light_lane_queue_controller.sv */
// Four-approach intersection controller with a car queue per approach.
//
// Input channel: raise start with a word on item; the word is taken at the
// rising edge where start is high and busy is low. busy stays low, so a word
// can be taken on every cycle.
// Kinds: tick advances the light cycle, arrival queues a car id, request asks
// whether that car may cross, done pops the head car of the approach.
//
// Result channel: every taken word yields exactly one result word, shown on
// result for one cycle with result_valid high. The input register loads at the
// accepting edge and the result register after it, and the receiver takes the
// result from the result register. One result per cycle comes out at full
// rate. The receiver cannot stall.
//
// Config channel: cfg_ready is always high; index 0 writes green_ticks,
// index 1 writes yellow_ticks, others are dropped. Write only while idle.
//
// Reset (arst_n low): group 2-3 green, tick counter at zero, all queues empty,
// green_ticks 5, yellow_ticks 1. The id store is not cleared; a slot's contents
// are used only after a car has been written into it.
module traffic_light_lane_queue_controller #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_WIDTH    = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  tlqc_pkg::in_word_t               item,
	output logic                             result_valid,
	output tlqc_pkg::out_word_t              result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tlqc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tlqc_pkg::TICK_W-1:0]      cfg_data
);
	import tlqc_pkg::*;

	`include "traffic_light_lane_queue_controller_macros.svh"

	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int STORE_W = (ID_WIDTH < CAR_ID_W) ? ID_WIDTH : CAR_ID_W;
	localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(QUEUE_DEPTH);

	logic               accept;
	lane_ctl_t          ctl;
	logic [CNT_W-1:0]   count_cur;
	logic [CNT_W-1:0]   count_nxt;
	logic [STORE_W-1:0] head_s1;
	logic               full;
	logic               empty;
	phase_t             phase_d;
	light_t             light_d;
	status_t            pre_status;

	// first stage: item as taken, plus everything but the head compare
	logic               s1_valid;
	kind_t              kind_s1;
	logic [STORE_W-1:0] id_s1;
	status_t            status_s1;
	light_t             light_s1;
	logic [COUNT_W-1:0] count_s1;
	logic               req_ok_s1;

	// result register
	logic               result_valid_q;
	out_word_t          result_q;
	status_t            final_status;

	// result flags watched by the checks below
	logic               res_full;
	logic               res_empty;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Decide the queue action from the current lane count.
	always_comb begin
		full         = (count_cur >= CNT_W'(QUEUE_DEPTH));
		empty        = (count_cur == '0);
		ctl.approach = item.approach;
		ctl.push     = accept && (item.kind == KIND_ARRIVE) && !full;
		ctl.pop      = accept && (item.kind == KIND_DONE) && !empty;
		light_d      = light_of(item.approach, phase_d);
		case (item.kind)
			KIND_ARRIVE: pre_status = full ? ST_FULL : ST_OK;
			KIND_DONE:   pre_status = empty ? ST_EMPTY : ST_OK;
			KIND_REQUEST: pre_status = ST_WAIT;
			default:     pre_status = ST_OK;
		endcase
	end

	tlqc_phase u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (accept && (item.kind == KIND_TICK)),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.phase_d   (phase_d)
	);

	// The lane block reads the head slot at the accepting edge; the compare
	// against the requested id happens in the following cycle.
	tlqc_lanes #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.STORE_W     (STORE_W)
	) u_lanes (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.wr_id     (item.car_id[STORE_W-1:0]),
		.count_cur (count_cur),
		.count_nxt (count_nxt),
		.head_s1   (head_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= accept;
		end
	end

	// payload of the first stage
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= item.kind;
			id_s1     <= item.car_id[STORE_W-1:0];
			status_s1 <= pre_status;
			light_s1  <= light_d;
			count_s1  <= COUNT_W'(count_nxt);
			req_ok_s1 <= (light_d == LIGHT_GREEN) && !empty;
		end
	end

	// Grant a request only when green, queue non-empty and the head matches.
	always_comb begin
		final_status = status_s1;
		if (kind_s1 == KIND_REQUEST) begin
			final_status = (req_ok_s1 && (head_s1 == id_s1)) ? ST_OK : ST_WAIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid) begin
			result_q.status      <= final_status;
			result_q.light       <= light_s1;
			result_q.queue_count <= count_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign res_full  = result_valid && (result.status == ST_FULL);
	assign res_empty = result_valid && (result.status == ST_EMPTY);

	`TLQC_ASSERT(a_stage_follows_accept, accept |=> s1_valid, "taken word lost")
	`TLQC_ASSERT(a_result_follows_stage, s1_valid |=> result_valid, "stage one word lost")
	`TLQC_ASSERT_IMPL(a_full_count, res_full, result.queue_count == FULL_COUNT, "reject not full")
	`TLQC_ASSERT_IMPL(a_empty_count, res_empty, result.queue_count == '0, "empty flag on cars")

endmodule
